// ===== hw/rtl/wcp_pkg.sv =====
// wcp_pkg: shared types, chunk tags and status codes for the wav chunk parser
// used by wcp_core, wcp_out_fifo, wav_chunk_parser_top and wcp_checker
package wcp_pkg;

  localparam int unsigned OutDepth = 8;
  localparam int unsigned TdataBits = 144;
  localparam int unsigned TuserBits = 3;
  localparam int unsigned HeaderBytes = 12;
  localparam int unsigned IdBytes = 4;
  localparam int unsigned ChunkMinSize = 4;
  localparam int unsigned FmtMinSize = 16;
  localparam int unsigned PcmCode = 1;

  localparam logic [2:0] REG_LOCATE = 3'd0;

  localparam logic [31:0] TAG_FMT  = 32'h20746d66;
  localparam logic [31:0] TAG_DATA = 32'h61746164;

  localparam int unsigned NumKnown = 11;
  localparam logic [31:0] KNOWN_TAGS [NumKnown] = '{
    32'h74636166, 32'h6c766177, 32'h746e6c73, 32'h20657563,
    32'h74736c70, 32'h7473696c, 32'h6c62616c, 32'h65746f6e,
    32'h7478746c, 32'h6c706d73, 32'h74736e69
  };

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_FORMAT = 2'd1,
    KIND_LOC    = 2'd2,
    KIND_STATUS = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_SUBTYPE = 3'd1,
    ST_ZERO_RATE   = 3'd2,
    ST_BAD_SIZE    = 3'd3,
    ST_UNKNOWN     = 3'd4,
    ST_ABSENT      = 3'd5,
    ST_TRUNCATED   = 3'd6
  } status_t;

  typedef struct packed {
    kind_t       event_kind;
    logic [7:0]  data_byte;
    logic        chunk_last;
    logic [15:0] channel_count;
    logic [15:0] sample_bits;
    logic [31:0] sample_rate;
    logic [31:0] data_offset;
    logic [31:0] data_size;
    status_t     status;
    logic        run_last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    slot0;
    result_t    slot1;
  } push_t;

  function automatic logic is_known_tag(input logic [31:0] tag);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NumKnown; i++) begin
      if (KNOWN_TAGS[i] == tag) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

// ===== hw/rtl/wcp_core.sv =====
// wcp_core: input byte register and per-byte chunk parse, up to two result words
// depends on wcp_pkg
module wcp_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_accept,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  input  logic             locate_mode,
  output logic             in_busy,
  output wcp_pkg::push_t   push
);

  typedef enum logic [5:0] {
    PH_HDR  = 6'b000001,
    PH_ID   = 6'b000010,
    PH_SIZE = 6'b000100,
    PH_FMT  = 6'b001000,
    PH_DATA = 6'b010000,
    PH_SKIP = 6'b100000
  } phase_t;

  logic             in_valid;
  logic [7:0]       in_data;
  logic             in_end;

  phase_t           phase, phase_next;
  logic [31:0]      field_count, field_count_next;
  logic [31:0]      byte_position, byte_position_next;
  logic [31:0]      tag_shift, tag_shift_next;
  logic [31:0]      chunk_length, chunk_length_next;
  logic [31:0]      fmt_shift, fmt_shift_next;
  logic [31:0]      rate_seen, rate_seen_next;
  logic [15:0]      chan_hold, chan_hold_next;
  logic             data_seen, data_seen_next;
  logic             halted, halted_next;

  logic [31:0]      fc_inc;
  logic             err_hit;
  wcp_pkg::status_t err_code;
  logic             prim_valid;
  wcp_pkg::result_t prim;
  logic             stat_valid;
  wcp_pkg::result_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_accept;
    end
    if (in_accept) begin
      in_data <= in_byte;
      in_end  <= in_last;
    end
  end

  always_comb begin
    phase_next         = phase;
    field_count_next   = field_count;
    byte_position_next = byte_position;
    tag_shift_next     = tag_shift;
    chunk_length_next  = chunk_length;
    fmt_shift_next     = fmt_shift;
    rate_seen_next     = rate_seen;
    chan_hold_next     = chan_hold;
    data_seen_next     = data_seen;
    halted_next        = halted;
    fc_inc             = field_count + 32'd1;
    err_hit            = 1'b0;
    err_code           = wcp_pkg::ST_OK;
    prim_valid         = 1'b0;
    prim               = '0;
    stat_valid         = 1'b0;
    stat               = '0;

    if (in_valid && !halted) begin
      byte_position_next = byte_position + 32'd1;
      case (phase)
        PH_HDR: begin
          field_count_next = fc_inc;
          if (fc_inc >= 32'(wcp_pkg::HeaderBytes)) begin
            phase_next       = PH_ID;
            field_count_next = '0;
          end
        end
        PH_ID: begin
          tag_shift_next   = {in_data, tag_shift[31:8]};
          field_count_next = fc_inc;
          if (fc_inc >= 32'(wcp_pkg::IdBytes)) begin
            phase_next       = PH_SIZE;
            field_count_next = '0;
          end
        end
        PH_SIZE: begin
          chunk_length_next = {in_data, chunk_length[31:8]};
          field_count_next  = fc_inc;
          if (fc_inc >= 32'(wcp_pkg::IdBytes)) begin
            field_count_next = '0;
            if (chunk_length_next <= 32'(wcp_pkg::ChunkMinSize)) begin
              err_hit  = 1'b1;
              err_code = wcp_pkg::ST_BAD_SIZE;
            end else if (tag_shift == wcp_pkg::TAG_FMT) begin
              if (chunk_length_next < 32'(wcp_pkg::FmtMinSize)) begin
                err_hit  = 1'b1;
                err_code = wcp_pkg::ST_BAD_SIZE;
              end else begin
                phase_next = PH_FMT;
              end
            end else if (tag_shift == wcp_pkg::TAG_DATA) begin
              data_seen_next = 1'b1;
              if (locate_mode) begin
                prim_valid       = 1'b1;
                prim.event_kind  = wcp_pkg::KIND_LOC;
                prim.data_offset = byte_position_next;
                prim.data_size   = chunk_length_next;
                phase_next       = PH_SKIP;
              end else begin
                phase_next = PH_DATA;
              end
            end else if (wcp_pkg::is_known_tag(tag_shift)) begin
              phase_next = PH_SKIP;
            end else begin
              err_hit  = 1'b1;
              err_code = wcp_pkg::ST_UNKNOWN;
            end
          end
        end
        PH_FMT: begin
          fmt_shift_next = {in_data, fmt_shift[31:8]};
          if (field_count == 32'd1 &&
              fmt_shift_next[31:16] != 16'(wcp_pkg::PcmCode)) begin
            err_hit  = 1'b1;
            err_code = wcp_pkg::ST_BAD_SUBTYPE;
          end else if (field_count == 32'd3) begin
            chan_hold_next = fmt_shift_next[31:16];
          end else if (field_count == 32'd7) begin
            if (fmt_shift_next == '0) begin
              err_hit  = 1'b1;
              err_code = wcp_pkg::ST_ZERO_RATE;
            end else begin
              rate_seen_next = fmt_shift_next;
            end
          end else if (field_count == 32'd15) begin
            prim_valid         = 1'b1;
            prim.event_kind    = wcp_pkg::KIND_FORMAT;
            prim.channel_count = chan_hold;
            prim.sample_bits   = fmt_shift_next[31:16];
            prim.sample_rate   = rate_seen;
          end
          field_count_next = fc_inc;
          if (!err_hit && fc_inc == chunk_length) begin
            phase_next       = PH_ID;
            field_count_next = '0;
          end
        end
        PH_DATA: begin
          field_count_next = fc_inc;
          prim_valid       = 1'b1;
          prim.event_kind  = wcp_pkg::KIND_DATA;
          prim.data_byte   = in_data;
          if (fc_inc == chunk_length) begin
            prim.chunk_last  = 1'b1;
            phase_next       = PH_ID;
            field_count_next = '0;
          end
        end
        default: begin
          field_count_next = fc_inc;
          if (fc_inc == chunk_length) begin
            phase_next       = PH_ID;
            field_count_next = '0;
          end
        end
      endcase

      stat.event_kind = wcp_pkg::KIND_STATUS;
      stat.run_last   = 1'b1;
      if (err_hit) begin
        stat_valid  = 1'b1;
        stat.status = err_code;
      end else if (in_end) begin
        stat_valid = 1'b1;
        if (phase_next != PH_ID) begin
          stat.status = wcp_pkg::ST_TRUNCATED;
        end else if (data_seen_next && rate_seen_next != '0) begin
          stat.status = wcp_pkg::ST_OK;
        end else begin
          stat.status = wcp_pkg::ST_ABSENT;
        end
      end
      if (stat_valid) halted_next = 1'b1;
    end
  end

  always_comb begin
    push.count = {1'b0, prim_valid} + {1'b0, stat_valid};
    push.slot1 = stat;
    if (prim_valid) begin
      push.slot0          = prim;
      push.slot0.run_last = !stat_valid;
    end else begin
      push.slot0 = stat;
    end
  end

  assign in_busy = in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HDR;
      field_count   <= '0;
      byte_position <= '0;
      tag_shift     <= '0;
      chunk_length  <= '0;
      fmt_shift     <= '0;
      rate_seen     <= '0;
      chan_hold     <= '0;
      data_seen     <= 1'b0;
      halted        <= 1'b0;
    end else begin
      phase         <= phase_next;
      field_count   <= field_count_next;
      byte_position <= byte_position_next;
      tag_shift     <= tag_shift_next;
      chunk_length  <= chunk_length_next;
      fmt_shift     <= fmt_shift_next;
      rate_seen     <= rate_seen_next;
      chan_hold     <= chan_hold_next;
      data_seen     <= data_seen_next;
      halted        <= halted_next;
    end
  end

endmodule

// ===== hw/rtl/wcp_out_fifo.sv =====
// wcp_out_fifo: result word queue, takes up to two words a cycle, gives one
// depends on wcp_pkg; DEPTH must be a power of two, at least 4
module wcp_out_fifo #(
  parameter int unsigned DEPTH = wcp_pkg::OutDepth
) (
  input  logic                         clk,
  input  logic                         rst,
  input  wcp_pkg::push_t               push,
  input  logic                         pop,
  output logic                         not_empty,
  output logic [$clog2(DEPTH+1)-1:0]   level,
  output wcp_pkg::result_t             head
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  wcp_pkg::result_t mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.slot0;
    if (push.count == 2'd2) mem[wr_ptr + AW'(1)] <= push.slot1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push.count);
      if (pop) rd_ptr <= rd_ptr + AW'(1);
      count <= count + CW'(push.count) - CW'(pop);
    end
  end

  assign not_empty = (count != '0);
  assign level     = count;
  assign head      = mem[rd_ptr];

endmodule

// ===== hw/rtl/wav_chunk_parser_top.sv =====
// wav_chunk_parser_top: riff/wave chunk parser, byte stream in, event words out
// depends on wcp_pkg, wcp_core, wcp_out_fifo
//
// Takes one file byte per cycle on the s_ side while s_tready is high and gives one event word
// per cycle on the m_ side while words are queued and m_tready is high. A byte is parsed in the
// cycle after its accepting edge and its words (none, one or two) enter an OUT_DEPTH-entry
// output queue at the next edge. With m_tready held high the queue never holds more than two
// words and a byte is taken every cycle. s_tready drops when the queue could not take the words
// of both the byte being parsed and a new one: four words with a byte in the input register,
// two without; under sink stalls the byte rate then follows the word rate. Two words come
// only from the byte that also carries the final status. After a final status word the parser
// ignores every byte until reset. locate_mode is written at address 0 and must only change
// while no byte is in flight.
module wav_chunk_parser_top #(
  parameter int unsigned OUT_DEPTH = wcp_pkg::OutDepth
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // file_byte
  input  logic                          s_tlast,   // file_last
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // data_byte, channel_count, sample_bits, sample_rate, data_offset, data_size, status, zeros
  output logic [wcp_pkg::TdataBits-1:0] m_tdata,
  output logic                          m_tlast,   // chunk_last
  output logic [wcp_pkg::TuserBits-1:0] m_tuser,   // event_kind, run_last
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned CW = $clog2(OUT_DEPTH + 1);

  logic                   locate_mode;
  logic                   in_accept;
  logic                   in_busy;
  wcp_pkg::push_t         push;
  logic                   pop;
  logic [CW-1:0]          level;
  logic [CW+1:0]          need;
  wcp_pkg::result_t       head;

  always_ff @(posedge clk) begin
    if (rst) begin
      locate_mode <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == wcp_pkg::REG_LOCATE[2])) begin
      locate_mode <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == wcp_pkg::REG_LOCATE[2]) ? {31'd0, locate_mode} : 32'd0;

  assign need      = (CW+2)'(level) + (in_busy ? (CW+2)'(4) : (CW+2)'(2));
  assign s_tready  = (need <= (CW+2)'(OUT_DEPTH));
  assign in_accept = s_tvalid && s_tready;

  wcp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .in_accept   (in_accept),
    .in_byte     (s_tdata),
    .in_last     (s_tlast),
    .locate_mode (locate_mode),
    .in_busy     (in_busy),
    .push        (push)
  );

  assign pop = m_tvalid && m_tready;

  wcp_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .not_empty (m_tvalid),
    .level     (level),
    .head      (head)
  );

  assign m_tdata = {5'd0, head.status, head.data_size, head.data_offset, head.sample_rate,
                    head.sample_bits, head.channel_count, head.data_byte};
  assign m_tlast = head.chunk_last;
  assign m_tuser = {head.run_last, head.event_kind};

endmodule

// ===== hw/rtl/wcp_checker.sv =====
// wcp_checker: port-level checks on the parser's result stream, bound to the top level
// depends on wcp_pkg and wav_chunk_parser_top
module wcp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [wcp_pkg::TdataBits-1:0] m_tdata,
  input logic                          m_tlast,
  input logic [wcp_pkg::TuserBits-1:0] m_tuser
);

  // queue empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid right after reset");

  a_last_on_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[1:0] == wcp_pkg::KIND_DATA)
    else $error("chunk_last on a word that is not a data byte");

  a_status_ends_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] == wcp_pkg::KIND_STATUS |-> m_tuser[2])
    else $error("final status word without run_last");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] != wcp_pkg::KIND_STATUS |-> m_tdata[138:136] == wcp_pkg::ST_OK)
    else $error("nonzero status on a non-status word");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed");

endmodule

bind wav_chunk_parser_top wcp_checker u_wcp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
